// ===== rtl/core/sbds_pkg.sv =====
// Shared types and constants for the serial clock divisor search block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sbds_pkg;

  localparam int HZ_W        = 32;
  localparam int PRE_N       = 8;
  localparam int RATE_N      = 9;
  localparam int PRE_W       = 3;
  localparam int RSEL_W      = 4;
  localparam int RATE_VAL_W  = HZ_W - 1;

  localparam logic [HZ_W-1:0] BUS_CLOCK_RESET = 32'd24000000;

  // Prescaled bus clock for each prescaler choice.
  typedef logic [PRE_N-1:0][HZ_W-1:0] pre_arr_t;

  // One candidate setting on its way through the selection tree.
  typedef struct packed {
    logic                  fit;
    logic [RATE_VAL_W-1:0] rate;
    logic [PRE_W-1:0]      psel;
    logic [RSEL_W-1:0]     rsel;
  } cand_t;

  // Status of the prescaler table toward the search pipeline.
  typedef struct packed {
    logic     busy;
    pre_arr_t pre;
  } pre_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbds_if.sv =====
// Valid/ready channel interfaces for the request and result sides.
// Depends on sbds_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sbds_in_if import sbds_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [HZ_W-1:0] req_rate_hz;

  modport source (output valid, output req_rate_hz, input ready);
  modport sink   (input valid, input req_rate_hz, output ready);
endinterface

interface sbds_out_if import sbds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PRE_W-1:0]  prescale_sel;
  logic [RSEL_W-1:0] rate_sel;

  modport source (output valid, output prescale_sel, output rate_sel, input ready);
  modport sink   (input valid, input prescale_sel, input rate_sel, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sbds_pre_table.sv =====
// Prescaler table: divides the bus clock by 1 to 8 with shifts and reciprocal
// multiplication. Depends on sbds_pkg; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none

module sbds_pre_table import sbds_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [HZ_W-1:0] cfg_wdata,
  output pre_stat_t            stat
);

  // Rounded-up reciprocals; each gives the exact floor for any 32-bit dividend.
  localparam logic [HZ_W-1:0] RECIP3 = 32'hAAAA_AAAB;
  localparam logic [HZ_W-1:0] RECIP5 = 32'hCCCC_CCCD;
  localparam logic [HZ_W:0]   RECIP7 = 33'h1_2492_4925;

  logic [HZ_W-1:0]   src_r;
  logic              busy_r;
  pre_arr_t          quo_r;
  pre_arr_t          quo_nxt;
  logic [2*HZ_W-1:0] prod3;
  logic [2*HZ_W-1:0] prod5;
  logic [2*HZ_W:0]   prod7;

  assign prod3 = (2*HZ_W)'(src_r) * (2*HZ_W)'(RECIP3);
  assign prod5 = (2*HZ_W)'(src_r) * (2*HZ_W)'(RECIP5);
  assign prod7 = (2*HZ_W+1)'(src_r) * (2*HZ_W+1)'(RECIP7);

  // Division by 6 halves the quotient by 3, which gives the same floor.
  always_comb begin
    quo_nxt[0] = src_r;
    quo_nxt[1] = src_r >> 1;
    quo_nxt[2] = HZ_W'(prod3[2*HZ_W-1:HZ_W+1]);
    quo_nxt[3] = src_r >> 2;
    quo_nxt[4] = HZ_W'(prod5[2*HZ_W-1:HZ_W+2]);
    quo_nxt[5] = HZ_W'(prod3[2*HZ_W-1:HZ_W+2]);
    quo_nxt[6] = HZ_W'(prod7[2*HZ_W:HZ_W+3]);
    quo_nxt[7] = src_r >> 3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= BUS_CLOCK_RESET;
      busy_r <= 1'b1;
    end else if (cfg_we) begin
      src_r  <= cfg_wdata;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.pre  = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/spi_baud_divisor_search_unit.sv =====
// Top level of the serial clock divisor search block.
// Depends on sbds_pkg, sbds_if and sbds_pre_table.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The in_chan channel carries one requested serial clock rate per transaction;
// the out_chan channel returns one prescaler/divisor pair per request, in order.
// The pair chosen gives the highest rate that does not exceed the request; equal
// rates go to the lower prescaler and then the lower divisor. If no pair fits,
// the result is zero and zero.
// The bus clock register is written through cfg_we/cfg_wdata; the user must do
// so only while the block is idle, as the block does not enforce it. After reset
// and after every write the prescaler table loads the bus clock divided by 1 to
// 8 into its register, with in_chan.ready held low; no request is taken meanwhile.
// Throughput is one transaction per cycle while the table is not busy and the
// receiver does not stall. A request passes five pipeline registers before its
// result appears: compare, per-prescaler pick, and a three-level selection tree.
// When the receiver stalls, each stage holds its transaction; empty stages still
// fill, so new requests are taken until the pipeline is full. Nothing is lost
// or repeated.
module spi_baud_divisor_search_unit import sbds_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [HZ_W-1:0] cfg_wdata,
  sbds_in_if.sink              in_chan,
  sbds_out_if.source           out_chan
);

  // Candidate b replaces a only when b fits and a does not, or when both fit and
  // b has a strictly higher rate, which keeps the earlier pair on a tie.
  function automatic cand_t pick(input cand_t a, input cand_t b);
    if (b.fit && (!a.fit || (b.rate > a.rate))) begin
      return b;
    end
    return a;
  endfunction

  pre_stat_t pstat;

  sbds_pre_table u_pre_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .stat     (pstat)
  );

  // Stage valid bits and per-stage advance enables.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic en1, en2, en3, en4, en_o;
  logic in_fire;

  assign en_o    = !out_v_r || out_chan.ready;
  assign en4     = !s4_v_r || en_o;
  assign en3     = !s3_v_r || en4;
  assign en2     = !s2_v_r || en3;
  assign en1     = !s1_v_r || en2;
  assign in_chan.ready = !pstat.busy && en1;
  assign in_fire = in_chan.valid && in_chan.ready;

  // Stage 1: compare all 72 candidate rates against the request.
  logic [RATE_N-1:0] fit_c [PRE_N];
  logic [RATE_N-1:0] s1_fit_r [PRE_N];

  always_comb begin
    logic [RATE_VAL_W-1:0] rate;
    for (int p = 0; p < PRE_N; p++) begin
      for (int r = 0; r < RATE_N; r++) begin
        rate        = RATE_VAL_W'(pstat.pre[p] >> (r + 1));
        fit_c[p][r] = {1'b0, rate} <= in_chan.req_rate_hz;
      end
    end
  end

  // Stage 2: within one prescaler the rate falls as the divisor grows, so the
  // lowest fitting divisor is that prescaler's best pair.
  cand_t s2_c [PRE_N];
  cand_t s2_r [PRE_N];

  always_comb begin
    for (int p = 0; p < PRE_N; p++) begin
      s2_c[p].fit  = |s1_fit_r[p];
      s2_c[p].psel = PRE_W'(p);
      s2_c[p].rsel = '0;
      for (int r = RATE_N - 1; r >= 0; r--) begin
        if (s1_fit_r[p][r]) begin
          s2_c[p].rsel = RSEL_W'(r);
        end
      end
      s2_c[p].rate = RATE_VAL_W'(pstat.pre[p] >> (s2_c[p].rsel + RSEL_W'(1)));
    end
  end

  // Stages 3 to 5: selection tree over the eight prescalers, lower index on
  // the left so that ties resolve toward it.
  cand_t s3_r [PRE_N/2];
  cand_t s4_r [PRE_N/4];
  cand_t fin_c;

  assign fin_c = pick(s4_r[0], s4_r[1]);

  logic [PRE_W-1:0]  out_psel_r;
  logic [RSEL_W-1:0] out_rsel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r  <= in_fire;
      if (en2) s2_v_r  <= s1_v_r;
      if (en3) s3_v_r  <= s2_v_r;
      if (en4) s4_v_r  <= s3_v_r;
      if (en_o) out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int p = 0; p < PRE_N; p++) s1_fit_r[p] <= fit_c[p];
    end
    if (en2) begin
      for (int p = 0; p < PRE_N; p++) s2_r[p] <= s2_c[p];
    end
    if (en3) begin
      for (int i = 0; i < PRE_N/2; i++) s3_r[i] <= pick(s2_r[2*i], s2_r[2*i+1]);
    end
    if (en4) begin
      for (int i = 0; i < PRE_N/4; i++) s4_r[i] <= pick(s3_r[2*i], s3_r[2*i+1]);
    end
    if (en_o) begin
      out_psel_r <= fin_c.fit ? fin_c.psel : '0;
      out_rsel_r <= fin_c.fit ? fin_c.rsel : '0;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.prescale_sel = out_psel_r;
  assign out_chan.rate_sel     = out_rsel_r;

endmodule

`default_nettype wire

// ===== rtl/core/sbds_checker.sv =====
// Port-level checks for the divisor search block, bound to the top level.
// Depends on sbds_pkg and spi_baud_divisor_search_unit.
`timescale 1ns / 1ps
`default_nettype none

module sbds_checker import sbds_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              cfg_we,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [PRE_W-1:0]  out_prescale_sel,
  input wire logic [RSEL_W-1:0] out_rate_sel
);

  // The prescaler table is rebuilt right after reset; no request may enter.
  a_no_ready_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !in_ready)
    else $error("request accepted while the prescaler table was rebuilt");

  // A register write restarts the table, which blocks requests.
  a_no_ready_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("request accepted right after a bus clock write");

  a_rate_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rate_sel <= RSEL_W'(RATE_N - 1)))
    else $error("divisor choice out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_prescale_sel) && $stable(out_rate_sel)))
    else $error("stalled result changed or dropped");

endmodule

bind spi_baud_divisor_search_unit sbds_checker u_sbds_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_we          (cfg_we),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_prescale_sel(out_chan.prescale_sel),
  .out_rate_sel    (out_chan.rate_sel)
);

`default_nettype wire
